// File: rtl/smt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smt_pkg
// shared types and constants of the toroidal shoreline marker
// ----------------------------------------------------------------------------
package smt_pkg;

    localparam int DEF_MAX_WIDTH  = 128;
    localparam int DEF_MAX_HEIGHT = 128;

    localparam int CODE_W  = 8;
    localparam int COORD_W = 8;
    localparam int POS_W   = 7;
    localparam int REG_IDX_W = 2;
    localparam int NBR_W   = 4;

    localparam logic [REG_IDX_W-1:0] REG_MAP_WIDTH  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_MAP_HEIGHT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_WATER_CODE = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_SAND_CODE  = 2'd3;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [NBR_W-1:0] NBR_FIRST  = 4'd0;
    localparam logic [NBR_W-1:0] NBR_CENTER = 4'd4;
    localparam logic [NBR_W-1:0] NBR_LAST   = 4'd8;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_HERE,
        S_HERE_CHK,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [COORD_W-1:0] width;
        logic [COORD_W-1:0] height;
        logic [CODE_W-1:0]  water;
        logic [CODE_W-1:0]  sand;
    } t_cfg;

endpackage
`default_nettype wire

// File: rtl/smt_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smt_ram
// single-port tile map memory with registered read data
// ----------------------------------------------------------------------------
module smt_ram #(
    parameter int DEPTH  = 16384,
    parameter int ADDR_W = 14
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_we,
    input  wire logic [ADDR_W-1:0]           i_addr,
    input  wire logic [smt_pkg::CODE_W-1:0]  i_wdata,
    output logic      [smt_pkg::CODE_W-1:0]  o_rdata
);
    import smt_pkg::*;

    logic [CODE_W-1:0] r_mem [DEPTH];
    logic [CODE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// File: rtl/smt_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smt_cfg
// configuration registers with clamped map size
// ----------------------------------------------------------------------------
module smt_cfg #(
    parameter int MAX_WIDTH  = smt_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = smt_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [smt_pkg::REG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [smt_pkg::CODE_W-1:0]     i_cfg_data,
    output smt_pkg::t_cfg                       o_cfg
);
    import smt_pkg::*;

    logic [COORD_W-1:0] r_map_width;
    logic [COORD_W-1:0] r_map_height;
    logic [CODE_W-1:0]  r_water_code;
    logic [CODE_W-1:0]  r_sand_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width  <= COORD_W'(128);
            r_map_height <= COORD_W'(128);
            r_water_code <= '0;
            r_sand_code  <= CODE_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MAP_WIDTH:  r_map_width  <= i_cfg_data;
                REG_MAP_HEIGHT: r_map_height <= i_cfg_data;
                REG_WATER_CODE: r_water_code <= i_cfg_data;
                REG_SAND_CODE:  r_sand_code  <= i_cfg_data;
            endcase
        end
    end

    // zero counts as one, oversize saturates
    always_comb begin
        priority if (r_map_width == '0) begin
            o_cfg.width = COORD_W'(1);
        end else if (int'(r_map_width) > MAX_WIDTH) begin
            o_cfg.width = COORD_W'(MAX_WIDTH);
        end else begin
            o_cfg.width = r_map_width;
        end
        priority if (r_map_height == '0) begin
            o_cfg.height = COORD_W'(1);
        end else if (int'(r_map_height) > MAX_HEIGHT) begin
            o_cfg.height = COORD_W'(MAX_HEIGHT);
        end else begin
            o_cfg.height = r_map_height;
        end
        o_cfg.water = r_water_code;
        o_cfg.sand  = r_sand_code;
    end

endmodule
`default_nettype wire

// File: rtl/smt_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smt_ctrl
// sequencer walking the 3x3 wrapped window through one shared compare
// ----------------------------------------------------------------------------
module smt_ctrl #(
    parameter int MAX_WIDTH  = smt_pkg::DEF_MAX_WIDTH,
    parameter int ADDR_W     = 14
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire smt_pkg::t_cfg                i_cfg,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic                         i_kind,
    input  wire logic [smt_pkg::POS_W-1:0]    i_pos_x,
    input  wire logic [smt_pkg::POS_W-1:0]    i_pos_y,
    input  wire logic [smt_pkg::CODE_W-1:0]   i_tile_in,
    output logic                              o_ram_we,
    output logic      [ADDR_W-1:0]            o_ram_addr,
    output logic      [smt_pkg::CODE_W-1:0]   o_ram_wdata,
    input  wire logic [smt_pkg::CODE_W-1:0]   i_ram_rdata,
    output logic                              o_valid,
    output logic      [smt_pkg::CODE_W-1:0]   o_tile_out,
    output logic                              o_became_sand,
    output logic                              o_out_of_range
);
    import smt_pkg::*;

    localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(MAX_WIDTH);

    t_state r_state, n_state;
    logic [COORD_W-1:0] r_x, n_x;
    logic [COORD_W-1:0] r_y, n_y;
    logic [CODE_W-1:0]  r_tile, n_tile;
    logic [CODE_W-1:0]  r_here, n_here;
    logic [NBR_W-1:0]   r_idx, n_idx;
    logic               r_shore, n_shore;
    logic               r_oor, n_oor;

    logic [COORD_W-1:0] x_minus, x_plus, y_minus, y_plus;
    logic [COORD_W-1:0] x_sel, y_sel;
    logic [NBR_W-1:0]   a_idx;
    logic               in_range;
    logic               is_water;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_shore <= 1'b0;
            r_oor   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_shore <= n_shore;
            r_oor   <= n_oor;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_y    <= n_y;
        r_tile <= n_tile;
        r_here <= n_here;
    end

    // wrapped neighbor coordinates
    always_comb begin
        x_minus = (r_x == '0) ? i_cfg.width - COORD_W'(1) : r_x - COORD_W'(1);
        x_plus  = (r_x + COORD_W'(1) == i_cfg.width) ? '0 : r_x + COORD_W'(1);
        y_minus = (r_y == '0) ? i_cfg.height - COORD_W'(1) : r_y - COORD_W'(1);
        y_plus  = (r_y + COORD_W'(1) == i_cfg.height) ? '0 : r_y + COORD_W'(1);
    end

    always_comb begin
        unique case (r_state)
            S_HERE_CHK: a_idx = NBR_FIRST;
            S_SCAN:     a_idx = r_idx + NBR_W'(1);
            default:    a_idx = NBR_CENTER;
        endcase
    end

    always_comb begin
        unique case (a_idx)
            4'd0:    begin x_sel = x_minus; y_sel = y_minus; end
            4'd1:    begin x_sel = r_x;     y_sel = y_minus; end
            4'd2:    begin x_sel = x_plus;  y_sel = y_minus; end
            4'd3:    begin x_sel = x_minus; y_sel = r_y;     end
            4'd5:    begin x_sel = x_plus;  y_sel = r_y;     end
            4'd6:    begin x_sel = x_minus; y_sel = y_plus;  end
            4'd7:    begin x_sel = r_x;     y_sel = y_plus;  end
            4'd8:    begin x_sel = x_plus;  y_sel = y_plus;  end
            default: begin x_sel = r_x;     y_sel = r_y;     end
        endcase
    end

    assign o_ram_addr  = ADDR_W'(y_sel) * ROW_STRIDE + ADDR_W'(x_sel);
    assign o_ram_wdata = r_tile;
    assign is_water    = (i_ram_rdata == i_cfg.water);
    assign in_range    = (COORD_W'(i_pos_x) < i_cfg.width)
                      && (COORD_W'(i_pos_y) < i_cfg.height);

    always_comb begin
        n_state  = r_state;
        n_x      = r_x;
        n_y      = r_y;
        n_tile   = r_tile;
        n_here   = r_here;
        n_idx    = r_idx;
        n_shore  = r_shore;
        n_oor    = r_oor;
        o_ram_we = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_x    = COORD_W'(i_pos_x);
                    n_y    = COORD_W'(i_pos_y);
                    n_tile = i_tile_in;
                    n_oor  = !in_range;
                    n_shore = 1'b0;
                    priority if (i_kind == KIND_QUERY && !in_range) begin
                        n_state = S_DONE;
                    end else if (i_kind == KIND_QUERY) begin
                        n_state = S_HERE;
                    end else if (in_range) begin
                        n_state = S_LOAD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_LOAD: begin
                o_ram_we = 1'b1;
                n_state  = S_IDLE;
            end
            S_HERE: begin
                n_state = S_HERE_CHK;
            end
            S_HERE_CHK: begin
                n_here  = i_ram_rdata;
                n_shore = 1'b0;
                n_idx   = NBR_FIRST;
                n_state = is_water ? S_DONE : S_SCAN;
            end
            S_SCAN: begin
                n_shore = r_shore | is_water;
                if (r_idx == NBR_LAST) begin
                    n_state = S_DONE;
                end else begin
                    n_idx = r_idx + NBR_W'(1);
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy           = (r_state != S_IDLE);
    assign o_valid        = (r_state == S_DONE);
    assign o_out_of_range = r_oor;
    assign o_became_sand  = r_shore && !r_oor;
    assign o_tile_out     = r_oor ? '0 : (r_shore ? i_cfg.sand : r_here);

`ifndef SYNTHESIS
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");
    a_write_only_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram_we |-> $past(start) && $past(!busy) && $past(i_kind) == KIND_LOAD)
        else $error("map write without a load transaction");
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_kind == KIND_QUERY) |=> busy)
        else $error("query accepted but sequencer idle");
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= NBR_LAST)
        else $error("neighbor index beyond window");
    a_sand_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_became_sand |-> !o_out_of_range)
        else $error("sand flagged on out of range query");
`endif

endmodule
`default_nettype wire

// File: rtl/shoreline_marker_torus.sv
`default_nettype none
// ----------------------------------------------------------------------------
// shoreline_marker_torus
// tile map on a torus that marks land tiles next to water as sand
// ----------------------------------------------------------------------------
// usage:
//   a transaction is taken when start is high and busy is low; i_kind selects
//   a load (write i_tile_in at i_pos_x, i_pos_y) or a query of that tile
//   loads give no result; an out of range load is dropped and busy stays low
//   a query gives one result on o_tile_out, o_became_sand and o_out_of_range,
//   marked by o_valid for exactly one cycle; the receiver cannot stall
//   load: accept moves to S_LOAD, which writes the tile; busy falls in S_IDLE
//   query in range: one read of the tile, then nine reads of the wrapped
//   3x3 window through the single map port, one per cycle, each checked by
//   the shared water compare, then o_valid in S_DONE and busy low in S_IDLE
//   (a water tile goes from its own read straight to S_DONE)
//   query out of range: o_valid in the cycle after accept
//   configuration: i_cfg_we writes register i_cfg_idx; the user writes only
//   while idle (not enforced); reset idles the sequencer, presets registers;
//   the map holds no reset value and must be loaded before it is queried
// ----------------------------------------------------------------------------
module shoreline_marker_torus #(
    parameter int MAX_WIDTH  = smt_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = smt_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic                           i_kind,
    input  wire logic [smt_pkg::POS_W-1:0]      i_pos_x,
    input  wire logic [smt_pkg::POS_W-1:0]      i_pos_y,
    input  wire logic [smt_pkg::CODE_W-1:0]     i_tile_in,
    input  wire logic                           i_cfg_we,
    input  wire logic [smt_pkg::REG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [smt_pkg::CODE_W-1:0]     i_cfg_data,
    output logic                                o_valid,
    output logic      [smt_pkg::CODE_W-1:0]     o_tile_out,
    output logic                                o_became_sand,
    output logic                                o_out_of_range
);
    import smt_pkg::*;

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);

    t_cfg              cfg;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [CODE_W-1:0] ram_wdata;
    logic [CODE_W-1:0] ram_rdata;

    smt_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    smt_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    smt_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .ADDR_W     (ADDR_W)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .start          (start),
        .busy           (busy),
        .i_kind         (i_kind),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_tile_in      (i_tile_in),
        .o_ram_we       (ram_we),
        .o_ram_addr     (ram_addr),
        .o_ram_wdata    (ram_wdata),
        .i_ram_rdata    (ram_rdata),
        .o_valid        (o_valid),
        .o_tile_out     (o_tile_out),
        .o_became_sand  (o_became_sand),
        .o_out_of_range (o_out_of_range)
    );

endmodule
`default_nettype wire
